@@ sv/hpt_pkg.sv @@
package hpt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW        = 32;
	localparam int AW        = 2 * CW - FRAC_BITS + 2;
	localparam int NW        = AW + FRAC_BITS;
	localparam int QB        = CW + 1;
	localparam int XW        = AW + QB + 1;
	localparam int NREG      = 8;
	localparam int IDXW      = 4;
	localparam int RW        = 64;

	localparam logic [CW-1:0] S32_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] S32_MIN = {1'b1, {(CW-1){1'b0}}};

	localparam logic [RW-1:0] ONE_LO = RW'(64'd1) << FRAC_BITS;
	localparam logic [RW-1:0] ONE_HI = RW'(64'd1) << (FRAC_BITS + CW);

	localparam logic ACT_POINT  = 1'b0;
	localparam logic ACT_NORMAL = 1'b1;

	typedef struct packed {
		logic                 action;
		logic signed [CW-1:0] in_x;
		logic signed [CW-1:0] in_y;
		logic signed [CW-1:0] in_z;
	} in_word_t;

	typedef struct packed {
		logic signed [CW-1:0] out_x;
		logic signed [CW-1:0] out_y;
		logic signed [CW-1:0] out_z;
		logic                 divide_fault;
	} out_word_t;

	typedef logic [NREG-1:0][RW-1:0] mat_regs_t;

	localparam mat_regs_t REGS_RESET = {ONE_HI, RW'(0), ONE_LO, RW'(0),
		RW'(0), ONE_HI, RW'(0), ONE_LO};

	typedef struct packed {
		logic [NW-1:0] num;
		logic [AW-1:0] den;
		logic [QB-1:0] quo;
		logic          neg;
		logic          ovf;
		logic          bypass;
		logic [CW-1:0] byp_val;
		logic          fault;
	} div_word_t;

	function automatic logic [CW-1:0] sat32(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] hi;
		logic signed [AW-1:0] lo;
		hi = AW'($signed({1'b0, S32_MAX}));
		lo = AW'($signed(S32_MIN));
		if (v > hi)
			return S32_MAX;
		else if (v < lo)
			return S32_MIN;
		else
			return v[CW-1:0];
	endfunction

endpackage

@@ sv/homogeneous_point_transform_top.sv @@
// channel  | valid     | stall     | word
// input    | in_valid  | in_stall  | in_data  (action, in_x, in_y, in_z)
// output   | out_valid | out_stall | out_data (out_x, out_y, out_z, divide_fault)
// config   | cfg_wr    | -         | cfg_index, cfg_data
// One word enters per cycle unless the output stalls. There are 38 register
// stages: two multiply/sum stages, a sign prep stage, an overflow check stage,
// one restoring divide stage per quotient bit (33), and the output register.
// Reset clears all valid bits and loads the identity matrix.
// A stalled output word freezes the whole pipeline and raises in_stall.
module homogeneous_point_transform_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  hpt_pkg::in_word_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output hpt_pkg::out_word_t           out_data,
	input  logic                         cfg_wr,
	input  logic [hpt_pkg::IDXW-1:0]     cfg_index,
	input  logic [hpt_pkg::RW-1:0]       cfg_data
);
	import hpt_pkg::*;

	mat_regs_t            regs_q;
	logic                 en;
	logic                 valid_s2;
	logic                 normal_s2;
	logic signed [AW-1:0] acc_s2 [4];
	logic                 lv [3];
	logic [CW-1:0]        lr [3];
	logic                 lf [3];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REGS_RESET;
		end else if (cfg_wr && cfg_index < IDXW'(NREG)) begin
			regs_q[cfg_index[$clog2(NREG)-1:0]] <= cfg_data;
		end
	end

	hpt_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.regs      (regs_q),
		.valid_s2  (valid_s2),
		.normal_s2 (normal_s2),
		.acc_s2    (acc_s2)
	);

	for (genvar c = 0; c < 3; c++) begin : g_lane
		hpt_div u_div (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.valid       (valid_s2),
			.normal      (normal_s2),
			.acc         (acc_s2[c]),
			.w           (acc_s2[3]),
			.res_valid_q (lv[c]),
			.res_q       (lr[c]),
			.fault_q     (lf[c])
		);
	end

	assign out_valid             = lv[0];
	assign out_data.out_x        = lr[0];
	assign out_data.out_y        = lr[1];
	assign out_data.out_z        = lr[2];
	assign out_data.divide_fault = lf[0];

endmodule

@@ sv/hpt_mac.sv @@
module hpt_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  hpt_pkg::in_word_t           in_data,
	input  hpt_pkg::mat_regs_t          regs,
	output logic                        valid_s2,
	output logic                        normal_s2,
	output logic signed [hpt_pkg::AW-1:0] acc_s2 [4]
);
	import hpt_pkg::*;

	logic signed [2*CW-1:0] prod_s1 [4][3];
	logic signed [CW-1:0]   trans_s1 [4];
	logic                   normal_s1;
	logic                   valid_s1;

	logic signed [CW-1:0] vec [3];
	logic signed [CW-1:0] coef [4][4];
	logic signed [AW-1:0] acc_d [4];

	always_comb begin
		vec[0] = in_data.in_x;
		vec[1] = in_data.in_y;
		vec[2] = in_data.in_z;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (c[0])
					coef[r][c] = $signed(regs[r*2 + c/2][RW-1:CW]);
				else
					coef[r][c] = $signed(regs[r*2 + c/2][CW-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			normal_s1 <= (in_data.action == ACT_NORMAL);
			for (int c = 0; c < 4; c++) begin
				trans_s1[c] <= (in_data.action == ACT_NORMAL) ? '0 : coef[3][c];
				for (int r = 0; r < 3; r++)
					prod_s1[c][r] <= coef[r][c] * vec[r];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			acc_d[c] = AW'(trans_s1[c]);
			for (int r = 0; r < 3; r++)
				acc_d[c] = acc_d[c] + AW'(prod_s1[c][r] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			normal_s2 <= normal_s1;
			for (int c = 0; c < 4; c++)
				acc_s2[c] <= acc_d[c];
		end
	end

endmodule

@@ sv/hpt_div.sv @@
module hpt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid,
	input  logic                          normal,
	input  logic signed [hpt_pkg::AW-1:0] acc,
	input  logic signed [hpt_pkg::AW-1:0] w,
	output logic                          res_valid_q,
	output logic [hpt_pkg::CW-1:0]        res_q,
	output logic                          fault_q
);
	import hpt_pkg::*;

	localparam int NS = QB + 2;

	div_word_t st [NS];
	logic      vld [NS];
	div_word_t prep;
	div_word_t ovf_d;
	logic [CW-1:0] fin;

	always_comb begin
		logic          wz;
		logic [AW-1:0] an;
		wz = (w == '0);
		an = acc[AW-1] ? AW'(-acc) : acc;
		prep.num     = {an, {FRAC_BITS{1'b0}}};
		prep.den     = w[AW-1] ? AW'(-w) : w;
		prep.quo     = '0;
		prep.neg     = acc[AW-1] ^ w[AW-1];
		prep.ovf     = 1'b0;
		prep.bypass  = normal | wz;
		prep.fault   = !normal & wz;
		if (normal)
			prep.byp_val = sat32(acc);
		else if (acc > 0)
			prep.byp_val = S32_MAX;
		else if (acc < 0)
			prep.byp_val = S32_MIN;
		else
			prep.byp_val = '0;
	end

	always_comb begin
		ovf_d     = st[0];
		ovf_d.ovf = XW'(st[0].num) >= (XW'(st[0].den) << QB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++)
				vld[k] <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld[0] <= valid;
			for (int k = 1; k < NS; k++)
				vld[k] <= vld[k-1];
			res_valid_q <= vld[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st[0] <= prep;
			st[1] <= ovf_d;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int SH = QB - 1 - k;
		logic [XW-1:0] trial;
		logic          take;
		div_word_t     nxt;
		assign trial = XW'(st[k+1].den) << SH;
		assign take  = XW'(st[k+1].num) >= trial;
		always_comb begin
			nxt = st[k+1];
			if (take) begin
				nxt.num     = st[k+1].num - trial[NW-1:0];
				nxt.quo[SH] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st[k+2] <= nxt;
			end
		end
	end

	always_comb begin
		div_word_t l;
		l = st[NS-1];
		if (l.bypass)
			fin = l.byp_val;
		else if (l.ovf)
			fin = l.neg ? S32_MIN : S32_MAX;
		else if (l.neg)
			fin = (l.quo > QB'(S32_MIN)) ? S32_MIN : CW'(-l.quo[CW-1:0]);
		else
			fin = (l.quo > QB'(S32_MAX)) ? S32_MAX : l.quo[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q   <= fin;
			fault_q <= st[NS-1].fault;
		end
	end

endmodule

@@ sv/hpt_checker.sv @@
module hpt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input hpt_pkg::out_word_t out_data
);
	import hpt_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("output word changed while stalled");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled with free output");

	a_fault_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_fault |->
			(out_data.out_x == S32_MAX || out_data.out_x == S32_MIN || out_data.out_x == 0))
		else $error("fault word not saturated");

endmodule

bind homogeneous_point_transform_top hpt_checker u_hpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
